// ----- src/cpbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coil PWM battery compensation package
// Shared widths, codes, reset values and unit status type for the coil PWM
// compare generator and its bit-serial arithmetic units.
// ----------------------------------------------------------------------------
package cpbc_pkg;

    // Field and datapath widths.
    localparam int unsigned VAL_W       = 16;
    localparam int unsigned MUL_W       = 16;
    localparam int unsigned DIV_W       = 2 * MUL_W;
    localparam int unsigned CMD_W       = 3;
    localparam int unsigned PCT_W       = 8;
    localparam int unsigned DUTY_W      = 8;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 32;
    localparam int unsigned OUT_BITS    = VAL_W + 1 + DUTY_W;

    // Arithmetic constants.
    localparam logic [VAL_W-1:0]  PCT_FULL = 16'd100;
    localparam logic [VAL_W-1:0]  MILLI    = 16'd1000;
    localparam logic [VAL_W-1:0]  U16_MAX  = 16'hFFFF;
    localparam logic [DUTY_W-1:0] DUTY_SAT = 8'hFF;

    // Register reset values.
    localparam logic [VAL_W-1:0] TOP_RST  = 16'd256;
    localparam logic [VAL_W-1:0] MAXC_RST = 16'd250;
    localparam logic [VAL_W-1:0] NOM_RST  = 16'd12000;

    // Command codes carried in the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_SET_PERCENT = 3'd0,
        CMD_SET_RAW     = 3'd1,
        CMD_BATTERY     = 3'd2,
        CMD_FUSE        = 3'd3,
        CMD_UNFUSE      = 3'd4,
        CMD_CALIBRATE   = 3'd5
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_TIMER_TOP   = 3'd0,
        REG_MAX_COMPARE = 3'd1,
        REG_RESISTANCE  = 3'd2,
        REG_NOMINAL     = 3'd3,
        REG_LOCK_CUR    = 3'd4
    } t_reg_idx;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MUL1,
        S_DIV1,
        S_MUL2,
        S_DIV2,
        S_DUTY_MUL,
        S_DUTY_DIV,
        S_FINISH
    } t_state;

    // Status reported by a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

// ----- src/cpbc_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-and-add multiplier: one multiplier bit per cycle. The product is held
// until the next start.
// ----------------------------------------------------------------------------
module cpbc_mul (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [cpbc_pkg::MUL_W-1:0]      i_mcand,
    input  logic [cpbc_pkg::MUL_W-1:0]      i_mplier,
    output logic [2*cpbc_pkg::MUL_W-1:0]    o_product,
    output cpbc_pkg::t_unit_stat            o_stat
);
    import cpbc_pkg::*;

    localparam int unsigned CNT_W = $clog2(MUL_W);

    logic [MUL_W-1:0] r_mcand;
    logic [MUL_W-1:0] r_hi;
    logic [MUL_W-1:0] r_lo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [MUL_W:0]   w_sum;

    // Add the multiplicand when the current multiplier bit is set.
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);

    // Control: busy flag, step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the partial sum shifts right into the low half.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_hi    <= '0;
            r_lo    <= i_mplier;
        end else if (r_busy) begin
            r_hi <= w_sum[MUL_W:1];
            r_lo <= {w_sum[0], r_lo[MUL_W-1:1]};
        end
    end

    assign o_product   = {r_hi, r_lo};
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ----- src/cpbc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring divider: one quotient bit per cycle.
// The divisor must be nonzero; the quotient is held until the next start.
// ----------------------------------------------------------------------------
module cpbc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [cpbc_pkg::DIV_W-1:0]      i_dividend,
    input  logic [cpbc_pkg::VAL_W-1:0]      i_divisor,
    output logic [cpbc_pkg::DIV_W-1:0]      o_quotient,
    output cpbc_pkg::t_unit_stat            o_stat
);
    import cpbc_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] r_quo;
    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [VAL_W:0]   w_trial;
    logic [VAL_W:0]   w_diff;
    logic             w_fit;

    // Trial subtraction of the divisor from the shifted remainder.
    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};

    // Control: busy flag, step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend bits leave at the top, quotient bits enter below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[VAL_W-1:0] : w_trial[VAL_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_fit};
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ----- src/coil_pwm_battery_compensation_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coil PWM battery compensation core
// Keeps the coil setpoint, lock level and compare value, and reports the
// compare value, fuse state and duty percent after each command.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis channel, the command code in tuser and its
//   operands in tdata. Each request yields exactly one result on m_axis.
//   Configuration registers are written on the cfg channel, which is always
//   ready; write them only while no request is in flight.
//   Requests are handled one at a time by a sequencer that shares one
//   bit-serial 16x16 multiplier and one restoring 32/16 divider. Every
//   request ends with a duty computation (one multiply and one divide),
//   which a zero timer top skips. Percent and compensated battery requests
//   add one multiply and one divide before it, and a calibration with all
//   pending registers nonzero adds two of each.
//   The next request can be accepted as soon as its result is registered,
//   even while that result still waits in the output register; when the
//   receiver stalls, the sequencer holds its next finished result until the
//   output register frees up.
//   Reset restores the configuration registers, fuse, setpoint, compare value,
//   calibration and lock level to their reset values and empties the output register.
// ----------------------------------------------------------------------------
module coil_pwm_battery_compensation_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Fields from bit 0: percent[7:0], lock_mode[8], raw_value[24:9],
    // battery_mv[40:25], zero fill.
    input  logic [cpbc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Fields from bit 0: command[2:0].
    input  logic [cpbc_pkg::CMD_W-1:0]          s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: compare_value[15:0], fused[16], duty_percent[24:17],
    // zero fill.
    output logic [cpbc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cpbc_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [cpbc_pkg::VAL_W-1:0]          i_cfg_data
);
    import cpbc_pkg::*;

    // Sequencer and latched request.
    t_state              r_state;
    t_state              n_state;
    logic                r_launched;
    logic [CMD_W-1:0]    r_cmd;
    logic [PCT_W-1:0]    r_pct;
    logic                r_mode;
    logic [VAL_W-1:0]    r_raw;
    logic [VAL_W-1:0]    r_vbat;

    // Configuration registers.
    logic [VAL_W-1:0]    r_timer_top;
    logic [VAL_W-1:0]    r_max_cmp;
    logic [VAL_W-1:0]    r_res_pend;
    logic [VAL_W-1:0]    r_nom_pend;
    logic [VAL_W-1:0]    r_cur_pend;

    // Coil state.
    logic                r_fuse;
    logic [VAL_W-1:0]    r_setpoint;
    logic [VAL_W-1:0]    r_compare;
    logic [VAL_W-1:0]    r_cal_res;
    logic [VAL_W-1:0]    r_cal_nom;
    logic [VAL_W-1:0]    r_lock;
    logic [VAL_W-1:0]    r_volts;
    logic [DUTY_W-1:0]   r_duty;

    // Output register.
    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_out_data;

    // Arithmetic unit connections.
    logic                w_mul_start;
    logic [MUL_W-1:0]    w_mul_a;
    logic [MUL_W-1:0]    w_mul_b;
    logic [DIV_W-1:0]    w_mul_p;
    t_unit_stat          w_mul_stat;
    logic                w_div_start;
    logic [VAL_W-1:0]    w_div_dsr;
    logic [DIV_W-1:0]    w_div_q;
    t_unit_stat          w_div_stat;

    // Helper values.
    logic [PCT_W-1:0]    w_pct_sat;
    logic                w_use_lock;
    logic [VAL_W-1:0]    w_scale;
    logic                w_comp;
    logic                w_cal_ok;
    logic                w_top_zero;
    logic [VAL_W-1:0]    w_raw_clamp;
    logic [VAL_W-1:0]    w_sp_clamp;
    logic [VAL_W-1:0]    w_q_sat;
    logic [VAL_W-1:0]    w_q_clamp;
    logic                w_step_done;

    // Operand conditioning and clamps.
    assign w_pct_sat   = (r_pct > PCT_FULL[PCT_W-1:0]) ? PCT_FULL[PCT_W-1:0] : r_pct;
    assign w_use_lock  = r_mode && (r_cal_res != '0) && (r_cal_nom != '0);
    assign w_scale     = w_use_lock ? r_lock : r_timer_top;
    assign w_comp      = !r_fuse && (r_vbat != '0) && (r_cal_nom != '0);
    assign w_cal_ok    = (r_res_pend != '0) && (r_nom_pend != '0) && (r_cur_pend != '0);
    assign w_top_zero  = (r_timer_top == '0);
    assign w_raw_clamp = (r_raw > r_max_cmp) ? r_max_cmp : r_raw;
    assign w_sp_clamp  = (r_setpoint > r_max_cmp) ? r_max_cmp : r_setpoint;
    assign w_q_sat     = (w_div_q[DIV_W-1:VAL_W] != '0) ? U16_MAX : w_div_q[VAL_W-1:0];
    assign w_q_clamp   = (w_q_sat > r_max_cmp) ? r_max_cmp : w_q_sat;

    // A launched unit finished in this cycle.
    assign w_step_done = r_launched && (w_mul_stat.done || w_div_stat.done);

    // Shared serial units.
    cpbc_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mcand   (w_mul_a),
        .i_mplier  (w_mul_b),
        .o_product (w_mul_p),
        .o_stat    (w_mul_stat)
    );

    cpbc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mul_p),
        .i_divisor  (w_div_dsr),
        .o_quotient (w_div_q),
        .o_stat     (w_div_stat)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) n_state = S_EXEC;
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_SET_PERCENT: n_state = S_MUL1;
                    CMD_BATTERY:     n_state = w_comp ? S_MUL1 : S_DUTY_MUL;
                    CMD_CALIBRATE:   n_state = w_cal_ok ? S_MUL1 : S_DUTY_MUL;
                    default:         n_state = S_DUTY_MUL;
                endcase
            end
            S_MUL1: begin
                if (w_step_done) n_state = S_DIV1;
            end
            S_DIV1: begin
                if (w_step_done) n_state = (r_cmd == CMD_CALIBRATE) ? S_MUL2 : S_DUTY_MUL;
            end
            S_MUL2: begin
                if (w_step_done) n_state = S_DIV2;
            end
            S_DIV2: begin
                if (w_step_done) n_state = S_DUTY_MUL;
            end
            S_DUTY_MUL: begin
                if (w_top_zero)       n_state = S_FINISH;
                else if (w_step_done) n_state = S_DUTY_DIV;
            end
            S_DUTY_DIV: begin
                if (w_step_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, unit starts and operand selection.
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        w_mul_start   = 1'b0;
        w_div_start   = 1'b0;
        w_mul_a       = r_compare;
        w_mul_b       = PCT_FULL;
        w_div_dsr     = r_timer_top;
        unique case (r_state)
            S_MUL1: begin
                w_mul_start = !r_launched;
                case (r_cmd)
                    CMD_SET_PERCENT: begin
                        w_mul_a = {{(MUL_W-PCT_W){1'b0}}, w_pct_sat};
                        w_mul_b = w_scale;
                    end
                    CMD_BATTERY: begin
                        w_mul_a = r_setpoint;
                        w_mul_b = r_cal_nom;
                    end
                    default: begin
                        w_mul_a = r_res_pend;
                        w_mul_b = r_cur_pend;
                    end
                endcase
            end
            S_DIV1: begin
                w_div_start = !r_launched;
                case (r_cmd)
                    CMD_SET_PERCENT: w_div_dsr = PCT_FULL;
                    CMD_BATTERY:     w_div_dsr = r_vbat;
                    default:         w_div_dsr = MILLI;
                endcase
            end
            S_MUL2: begin
                w_mul_start = !r_launched;
                w_mul_a     = r_volts;
                w_mul_b     = r_timer_top;
            end
            S_DIV2: begin
                w_div_start = !r_launched;
                w_div_dsr   = r_cal_nom;
            end
            S_DUTY_MUL: begin
                w_mul_start = !r_launched && !w_top_zero;
            end
            S_DUTY_DIV: begin
                w_div_start = !r_launched;
            end
            default: begin
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;

    // Control registers: state, launch flag and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launched  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state != n_state) begin
                r_launched <= 1'b0;
            end else if (w_mul_start || w_div_start) begin
                r_launched <= 1'b1;
            end
            if (r_state == S_FINISH && n_state == S_IDLE) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration registers and coil state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_top <= TOP_RST;
            r_max_cmp   <= MAXC_RST;
            r_res_pend  <= '0;
            r_nom_pend  <= NOM_RST;
            r_cur_pend  <= '0;
            r_fuse      <= 1'b0;
            r_setpoint  <= '0;
            r_compare   <= '0;
            r_cal_res   <= '0;
            r_cal_nom   <= NOM_RST;
            r_lock      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_TIMER_TOP:   r_timer_top <= i_cfg_data;
                    REG_MAX_COMPARE: r_max_cmp   <= i_cfg_data;
                    REG_RESISTANCE:  r_res_pend  <= i_cfg_data;
                    REG_NOMINAL:     r_nom_pend  <= i_cfg_data;
                    REG_LOCK_CUR:    r_cur_pend  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // Commands that settle without arithmetic.
            if (r_state == S_EXEC) begin
                case (r_cmd)
                    CMD_SET_RAW: begin
                        r_compare <= r_fuse ? '0 : w_raw_clamp;
                    end
                    CMD_BATTERY: begin
                        if (r_fuse)       r_compare <= '0;
                        else if (!w_comp) r_compare <= w_sp_clamp;
                    end
                    CMD_FUSE: begin
                        r_fuse    <= 1'b1;
                        r_compare <= '0;
                    end
                    CMD_UNFUSE: begin
                        r_fuse    <= 1'b0;
                        r_compare <= '0;
                    end
                    CMD_CALIBRATE: begin
                        if (w_cal_ok) begin
                            r_cal_res <= r_res_pend;
                            r_cal_nom <= r_nom_pend;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // First quotient lands in the setpoint or the compare value.
            if (r_state == S_DIV1 && w_step_done) begin
                case (r_cmd)
                    CMD_SET_PERCENT: r_setpoint <= w_div_q[VAL_W-1:0];
                    CMD_BATTERY:     r_compare  <= w_q_clamp;
                    default: begin
                    end
                endcase
            end
            // Second quotient of a calibration is the new lock level.
            if (r_state == S_DIV2 && w_step_done) begin
                r_lock <= w_div_q[VAL_W-1:0];
            end
        end
    end

    // Payload registers: latched request, intermediate voltage, duty, output.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd  <= s_axis_tuser;
            r_pct  <= s_axis_tdata[7:0];
            r_mode <= s_axis_tdata[8];
            r_raw  <= s_axis_tdata[24:9];
            r_vbat <= s_axis_tdata[40:25];
        end
        // Calibration voltage is limited to the nominal battery voltage.
        if (r_state == S_DIV1 && w_step_done) begin
            r_volts <= (w_div_q > {{(DIV_W-VAL_W){1'b0}}, r_cal_nom}) ? r_cal_nom
                                                                      : w_div_q[VAL_W-1:0];
        end
        // Duty percent saturates, and reports full scale for a zero timer top.
        if (r_state == S_DUTY_MUL && w_top_zero) begin
            r_duty <= DUTY_SAT;
        end else if (r_state == S_DUTY_DIV && w_step_done) begin
            r_duty <= (w_div_q[DIV_W-1:DUTY_W] != '0) ? DUTY_SAT : w_div_q[DUTY_W-1:0];
        end
        if (r_state == S_FINISH && n_state == S_IDLE) begin
            r_out_data <= {r_duty, r_fuse, r_compare};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, r_out_data};

    // A unit is never restarted while it is still working.
    a_mul_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_start |-> !w_mul_stat.busy)
        else $error("multiplier started while busy");

    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider started while busy");

    // Divisions are only launched with a nonzero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> (w_div_dsr != '0))
        else $error("divider started with zero divisor");

    // A fused coil always has a zero compare value.
    a_fuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fuse |-> (r_compare == '0))
        else $error("compare value nonzero while fused");

    // The two units never run at the same time.
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_stat.busy && w_div_stat.busy))
        else $error("multiplier and divider busy together");

endmodule
